[hdl/erim_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erim_pkg: shared types and constants of the engine rpm and injector monitor
// Holds the item structs, the register file struct, the register indexes,
// the sequencer states and the build-time feature switches.
// ----------------------------------------------------------------------------
package erim_pkg;

   // Feature switches and the short-pulse filter limit.
   localparam logic        ENABLE_INJ       = 1'b1;
   localparam logic        ENABLE_RPM       = 1'b1;
   localparam logic [15:0] MIN_INJ_WIDTH_US = 16'd300;

   // Serial divider geometry: dividend is rpm_factor, divisor the period.
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 24;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   // Configuration port geometry.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RPM_FACTOR       = 4'd0,
      REG_MIN_PERIOD_US    = 4'd1,
      REG_MAX_PERIOD_US    = 4'd2,
      REG_RPM_FLOOR        = 4'd3,
      REG_RPM_CEILING      = 4'd4,
      REG_STABLE_THRESHOLD = 4'd5,
      REG_STABLE_HOLD_MS   = 4'd6,
      REG_STOP_TIMEOUT_MS  = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic [31:0] rpm_factor;
      logic [23:0] min_period_us;
      logic [23:0] max_period_us;
      logic [15:0] rpm_floor;
      logic [15:0] rpm_ceiling;
      logic [15:0] stable_rpm_threshold;
      logic [31:0] stable_hold_ms;
      logic [31:0] stop_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [23:0] ignition_period_us;
      logic [15:0] injector_raw_us;
      logic [15:0] dead_time_us;
   } req_type;

   typedef struct packed {
      logic [15:0] engine_rpm;
      logic        engine_running;
      logic        engine_stable;
      logic [31:0] engine_start_ms;
      logic [15:0] injector_pulse_us;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DIV  = 2'd1,
      ST_WAIT = 2'd2
   } state_type;

endpackage

`default_nettype wire

[hdl/erim_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erim_csr: configuration register file
// Eight registers written through a valid/ready port; unknown indexes are
// dropped.
// ----------------------------------------------------------------------------
module erim_csr import erim_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output      cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_RPM_FACTOR:       cfg_in.rpm_factor           = csr_wdata;
            REG_MIN_PERIOD_US:    cfg_in.min_period_us        = csr_wdata[23:0];
            REG_MAX_PERIOD_US:    cfg_in.max_period_us        = csr_wdata[23:0];
            REG_RPM_FLOOR:        cfg_in.rpm_floor            = csr_wdata[15:0];
            REG_RPM_CEILING:      cfg_in.rpm_ceiling          = csr_wdata[15:0];
            REG_STABLE_THRESHOLD: cfg_in.stable_rpm_threshold = csr_wdata[15:0];
            REG_STABLE_HOLD_MS:   cfg_in.stable_hold_ms       = csr_wdata;
            REG_STOP_TIMEOUT_MS:  cfg_in.stop_timeout_ms      = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rpm_factor           <= 32'd60000000;
         cfg_ff.min_period_us        <= 24'd0;
         cfg_ff.max_period_us        <= 24'd1000000;
         cfg_ff.rpm_floor            <= 16'd0;
         cfg_ff.rpm_ceiling          <= 16'd9000;
         cfg_ff.stable_rpm_threshold <= 16'd400;
         cfg_ff.stable_hold_ms       <= 32'd1000;
         cfg_ff.stop_timeout_ms      <= 32'd1500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[hdl/erim_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erim_div: bit-serial restoring divider
// Shifts one quotient bit per cycle; the quotient holds after done pulses.
// ----------------------------------------------------------------------------
module erim_div import erim_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output      logic                  busy,
   output      logic                  done,
   output      logic [DIVIDEND_W-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so the low bits
         // carry it whether or not the trial subtraction succeeds.
         rem_in = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[hdl/engine_rpm_injector_monitor.sv]
`default_nettype none
// A response item is presented after the bit-serial divider has shifted out the
// rpm quotient, the sequencer has seen done and moved to its wait state, and
// the response register has been loaded, which waits while an unread response
// is held. A new item is taken only after the previous one has loaded the
// response register. Reset (synchronous, active high) loads the register
// defaults and clears all tracking state and the response valid flag.
// ----------------------------------------------------------------------------
// engine_rpm_injector_monitor: engine speed and injector monitor
// Converts the ignition period to rpm with a serial divider, tracks the
// running and stable flags with their timeouts, and corrects the injector
// pulse width for dead time.
// ----------------------------------------------------------------------------
module engine_rpm_injector_monitor import erim_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire req_type               req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      rsp_type               rsp_data,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   // Sequencer state and the captured request item.
   state_type state_ff, state_in;
   req_type   item_ff;

   // Tracking state carried from item to item.
   logic [31:0] last_act_ff, last_act_in;
   logic [31:0] last_stable_ff, last_stable_in;
   logic [31:0] start_ff, start_in;
   logic        running_ff, running_in;
   logic        stable_ff, stable_in;

   // Response register; it decouples the result from the next item.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                  req_take;
   logic                  load_rsp;
   logic                  div_busy;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] quotient;

   logic        period_ok;
   logic [15:0] rpm_capped;
   logic [15:0] rpm;
   logic        stop_expired;
   logic        hold_expired;
   logic [15:0] inj_actual;
   logic [15:0] pulse;
   logic        pulse_ok;

   erim_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The divider starts on the same edge that accepts the request item.
   erim_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_take),
      .dividend (cfg.rpm_factor),
      .divisor  (req_data.ignition_period_us),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_take = req_valid && req_ready;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = ST_DIV;
         end
         ST_DIV: if (div_done) begin
            state_in = ST_WAIT;
         end
         ST_WAIT: if (!rsp_valid_ff || rsp_ready) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output logic of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DIV:  req_ready = 1'b0;
         ST_WAIT: load_rsp  = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   // The period must lie strictly inside the window; a zero period never
   // passes the lower bound test, so it needs no separate check beyond this.
   assign period_ok = (item_ff.ignition_period_us != '0)
                   && (cfg.min_period_us < item_ff.ignition_period_us)
                   && (item_ff.ignition_period_us < cfg.max_period_us);

   // Clamp against the upper display limit first, then raise to the lower
   // limit, so the lower limit wins when the two cross.
   always_comb begin
      if (quotient[31:16] != '0 || quotient[15:0] >= cfg.rpm_ceiling) begin
         rpm_capped = cfg.rpm_ceiling;
      end else begin
         rpm_capped = quotient[15:0];
      end
      if (!ENABLE_RPM || !period_ok) begin
         rpm = '0;
      end else if (rpm_capped < cfg.rpm_floor) begin
         rpm = cfg.rpm_floor;
      end else begin
         rpm = rpm_capped;
      end
   end

   // Time differences wrap modulo 2^32.
   assign stop_expired = (32'(item_ff.now_ms - last_act_ff)) > cfg.stop_timeout_ms;
   assign hold_expired = (32'(item_ff.now_ms - last_stable_ff)) > cfg.stable_hold_ms;

   // Dead time correction saturates at zero before the short-pulse filter.
   assign inj_actual = (item_ff.injector_raw_us > item_ff.dead_time_us)
                     ? 16'(item_ff.injector_raw_us - item_ff.dead_time_us) : '0;
   assign pulse_ok   = ENABLE_INJ && (item_ff.injector_raw_us != '0)
                    && (inj_actual >= MIN_INJ_WIDTH_US);
   assign pulse      = pulse_ok ? inj_actual : '0;

   // State update, applied on the cycle the response register is loaded.
   // The stop check runs first and the rpm stage may set stable again.
   always_comb begin
      running_in     = running_ff;
      stable_in      = stable_ff;
      start_in       = start_ff;
      last_stable_in = last_stable_ff;
      last_act_in    = last_act_ff;
      if (ENABLE_INJ) begin
         if (stop_expired) begin
            running_in = 1'b0;
            stable_in  = 1'b0;
            start_in   = '0;
         end else begin
            running_in = 1'b1;
         end
      end
      if (ENABLE_RPM) begin
         if (rpm > cfg.stable_rpm_threshold) begin
            if (!stable_in) begin
               start_in = item_ff.now_ms;
            end
            stable_in      = 1'b1;
            last_stable_in = item_ff.now_ms;
         end else if (hold_expired) begin
            stable_in = 1'b0;
            start_in  = '0;
         end
      end
      if (pulse_ok) begin
         last_act_in = item_ff.now_ms;
      end
   end

   // Response register next values.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.engine_rpm        = rpm;
         rsp_data_in.engine_running    = running_in;
         rsp_data_in.engine_stable     = stable_in;
         rsp_data_in.engine_start_ms   = start_in;
         rsp_data_in.injector_pulse_us = pulse;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         last_act_ff    <= '0;
         last_stable_ff <= '0;
         start_ff       <= '0;
         running_ff     <= 1'b0;
         stable_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_rsp) begin
            last_act_ff    <= last_act_in;
            last_stable_ff <= last_stable_in;
            start_ff       <= start_in;
            running_ff     <= running_in;
            stable_ff      <= stable_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted item always starts a division and enters the divide state.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_DIV) && div_busy)
      else $error("accepted item did not start the divider");

   // The divider is never busy while a new item can be taken.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_busy)
      else $error("request ready while divider busy");

   // The start timestamp is only held while the stable flag is set.
   assert property (@(posedge clock) disable iff (reset)
      !stable_ff |-> (start_ff == '0))
      else $error("start time set while not stable");

   // A new response appears only out of the final sequencer state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WAIT))
      else $error("response raised outside the update state");

endmodule

`default_nettype wire
